### rtl/tlbp_pkg.sv
// Shared types and constants of the two-level branch predictor.
`timescale 1ns / 1ps
`default_nettype none
package tlbp_pkg;

  // Default table geometry
  localparam int HIST_DEPTH_DEF = 1024;
  localparam int PAT_DEPTH_DEF  = 1024;
  localparam int MAX_HIST_DEF   = 16;

  // Field widths
  localparam int ADDR_W    = 64;
  localparam int ADDR_SHR  = 2;
  localparam int DVD_W     = ADDR_W - ADDR_SHR;
  localparam int DCNT_W    = $clog2(DVD_W + 1);
  localparam int CNT_W     = 32;
  localparam int CTR_W     = 2;
  localparam int HLEN_W    = 5;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_ENTRIES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ENTRIES = 2'd2;

  // Register reset values
  localparam logic [HLEN_W-1:0] HLEN_RST     = 5'd4;
  localparam logic [CFG_W-1:0]  HENT_RST     = 11'd1024;
  localparam logic [CFG_W-1:0]  PENT_RST     = 11'd16;

  // Counter thresholds
  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_TAKEN = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDIV,
    ST_HRD,
    ST_PDIV,
    ST_PRD
  } state_t;

endpackage
`default_nettype wire

### rtl/two_level_branch_predictor.sv
// Top level of the per-address two-level branch predictor.
//
// Usage: each input transaction on in_* carries one resolved branch (address
// and outcome). The block looks up the per-address history, then the 2-bit
// counter that history selects, and returns on out_* the prediction, whether
// it matched, and the three running 32-bit counts. Both index reductions are
// remainders computed by one shared bit-serial unit, first of address bits
// [63:2], then of the MAX_HISTORY_BITS-bit history, each followed by a
// table read. One item is in work at a time; in_tready is high only while
// the sequencer is idle, so no new item is taken until the last one has
// been written back to the tables and its result registered.
// After reset a clearing pass over max(HISTORY_TABLE_DEPTH, PATTERN_TABLE_DEPTH)
// entries (1024 by default) zeroes both tables; no item is taken meanwhile.
// The result sits in an output register; the next item is accepted while it
// waits, and that item holds at its final step until the register is free.
// Configuration writes on cfg_* take effect at once.
`timescale 1ns / 1ps
`default_nettype none
module two_level_branch_predictor #(
  parameter int HISTORY_TABLE_DEPTH = tlbp_pkg::HIST_DEPTH_DEF,
  parameter int PATTERN_TABLE_DEPTH = tlbp_pkg::PAT_DEPTH_DEF,
  parameter int MAX_HISTORY_BITS    = tlbp_pkg::MAX_HIST_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [63:0] branch_address, [64] was_taken, [71:65] zero
  input  wire logic [tlbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] predicted_taken, [1] prediction_correct, [33:2] branches_seen,
  // [65:34] branches_taken, [97:66] predictions_correct, [103:98] zero
  output logic [tlbp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [tlbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlbp_pkg::CFG_W-1:0]       cfg_wdata
);
  import tlbp_pkg::*;

  localparam int HB   = MAX_HISTORY_BITS;
  localparam int HIW  = (HISTORY_TABLE_DEPTH > 1) ? $clog2(HISTORY_TABLE_DEPTH) : 1;
  localparam int PIW  = (PATTERN_TABLE_DEPTH > 1) ? $clog2(PATTERN_TABLE_DEPTH) : 1;
  localparam int HMW  = $clog2(HISTORY_TABLE_DEPTH + 1);
  localparam int PMW  = $clog2(PATTERN_TABLE_DEPTH + 1);
  localparam int MW   = (HMW > PMW) ? HMW : PMW;
  localparam int CLR_DEPTH = (HISTORY_TABLE_DEPTH > PATTERN_TABLE_DEPTH) ?
                             HISTORY_TABLE_DEPTH : PATTERN_TABLE_DEPTH;
  localparam int CW   = $clog2(CLR_DEPTH + 1);
  localparam int XW   = MW + CFG_W;

  // Configuration registers
  logic [HLEN_W-1:0] cfg_hlen_r;
  logic [CFG_W-1:0]  cfg_hent_r;
  logic [CFG_W-1:0]  cfg_pent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hlen_r <= HLEN_RST;
      cfg_hent_r <= HENT_RST;
      cfg_pent_r <= PENT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HISTORY_LENGTH:  cfg_hlen_r <= cfg_wdata[HLEN_W-1:0];
        REG_HIST_ENTRIES:    cfg_hent_r <= cfg_wdata;
        REG_PATTERN_ENTRIES: cfg_pent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp table moduli to [1, depth]
  logic [MW-1:0] hmod, pmod;

  always_comb begin
    if (cfg_hent_r == '0) begin
      hmod = MW'(1);
    end else if (XW'(cfg_hent_r) > XW'(HISTORY_TABLE_DEPTH)) begin
      hmod = MW'(HISTORY_TABLE_DEPTH);
    end else begin
      hmod = MW'(cfg_hent_r);
    end
    if (cfg_pent_r == '0) begin
      pmod = MW'(1);
    end else if (XW'(cfg_pent_r) > XW'(PATTERN_TABLE_DEPTH)) begin
      pmod = MW'(PATTERN_TABLE_DEPTH);
    end else begin
      pmod = MW'(cfg_pent_r);
    end
  end

  // History mask: bit i kept when the configured length exceeds i
  logic [HB-1:0] hist_mask;

  always_comb begin
    for (int i = 0; i < HB; i++) begin
      hist_mask[i] = ({1'b0, cfg_hlen_r} > 6'(i));
    end
  end

  // Sequencer registers
  state_t            state_r, state_nxt;
  logic [CW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              taken_r, taken_nxt;
  logic [HIW-1:0]    hidx_r, hidx_nxt;
  logic [PIW-1:0]    pidx_r, pidx_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  tkn_r, tkn_nxt;
  logic [CNT_W-1:0]  corr_r, corr_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Shared remainder unit
  logic               rem_start;
  logic [DCNT_W-1:0]  rem_nbits;
  logic [MW-1:0]      rem_mod;
  logic [DVD_W-1:0]   rem_dvd;
  logic               rem_done;
  logic [MW-1:0]      rem_val;

  tlbp_rem #(.MW(MW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .nbits    (rem_nbits),
    .modulus  (rem_mod),
    .dividend (rem_dvd),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Table ports
  logic              hist_we, hist_re;
  logic [HIW-1:0]    hist_waddr, hist_raddr;
  logic [HB-1:0]     hist_wdata, hist_q;
  logic              pat_we, pat_re;
  logic [PIW-1:0]    pat_waddr, pat_raddr;
  logic [CTR_W-1:0]  pat_wdata, pat_q;

  logic [HB-1:0]     hist_mem [HISTORY_TABLE_DEPTH];
  logic [CTR_W-1:0]  pat_mem  [PATTERN_TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    if (pat_re) begin
      pat_q <= pat_mem[pat_raddr];
    end
  end

  // Prediction and update terms
  logic             pred, corr;
  logic [CTR_W-1:0] ctr_upd;
  logic             out_free;

  always_comb begin
    pred = (pat_q >= CTR_TAKEN);
    corr = (pred == taken_r);
    if (taken_r) begin
      ctr_upd = (pat_q == CTR_MAX) ? pat_q : pat_q + CTR_W'(1);
    end else begin
      ctr_upd = (pat_q == CTR_MIN) ? pat_q : pat_q - CTR_W'(1);
    end
    out_free = !out_vld_r || out_tready;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    taken_nxt    = taken_r;
    hidx_nxt     = hidx_r;
    pidx_nxt     = pidx_r;
    seen_nxt     = seen_r;
    tkn_nxt      = tkn_r;
    corr_nxt     = corr_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    in_tready    = 1'b0;
    rem_start    = 1'b0;
    rem_nbits    = DCNT_W'(DVD_W);
    rem_mod      = hmod;
    rem_dvd      = in_tdata[ADDR_W-1:ADDR_SHR];
    hist_we      = 1'b0;
    hist_waddr   = hidx_r;
    hist_wdata   = ((hist_q << 1) | HB'(taken_r)) & hist_mask;
    hist_re      = 1'b0;
    hist_raddr   = rem_val[HIW-1:0];
    pat_we       = 1'b0;
    pat_waddr    = pidx_r;
    pat_wdata    = ctr_upd;
    pat_re       = 1'b0;
    pat_raddr    = rem_val[PIW-1:0];

    // Drop the result once taken
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep both tables to zero, one entry a cycle
        hist_we     = (CW'(HISTORY_TABLE_DEPTH) > clr_cnt_r);
        hist_waddr  = clr_cnt_r[HIW-1:0];
        hist_wdata  = '0;
        pat_we      = (CW'(PATTERN_TABLE_DEPTH) > clr_cnt_r);
        pat_waddr   = clr_cnt_r[PIW-1:0];
        pat_wdata   = CTR_MIN;
        clr_cnt_nxt = clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          rem_start = 1'b1;
          taken_nxt = in_tdata[ADDR_W];
          state_nxt = ST_HDIV;
        end
      end
      ST_HDIV: begin
        if (rem_done) begin
          hist_re   = 1'b1;
          hidx_nxt  = rem_val[HIW-1:0];
          state_nxt = ST_HRD;
        end
      end
      ST_HRD: begin
        // History is valid: reduce it by the pattern modulus
        rem_start = 1'b1;
        rem_nbits = DCNT_W'(HB);
        rem_mod   = pmod;
        rem_dvd   = {hist_q, {(DVD_W - HB){1'b0}}};
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        if (rem_done) begin
          pat_re    = 1'b1;
          pidx_nxt  = rem_val[PIW-1:0];
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        // Hold until the output register is free, then update and report
        if (out_free) begin
          hist_we      = 1'b1;
          pat_we       = 1'b1;
          seen_nxt     = seen_r + CNT_W'(1);
          tkn_nxt      = tkn_r + CNT_W'(taken_r);
          corr_nxt     = corr_r + CNT_W'(corr);
          out_vld_nxt  = 1'b1;
          out_data_nxt = {6'd0, corr_nxt, tkn_nxt, seen_nxt, corr, pred};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      seen_r    <= '0;
      tkn_r     <= '0;
      corr_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      seen_r    <= seen_nxt;
      tkn_r     <= tkn_nxt;
      corr_r    <= corr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taken_r    <= taken_nxt;
    hidx_r     <= hidx_nxt;
    pidx_r     <= pidx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/tlbp_rem.sv
// Bit-serial restoring remainder unit shared by both table index reductions.
`timescale 1ns / 1ps
`default_nettype none
module tlbp_rem #(
  parameter int MW = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tlbp_pkg::DCNT_W-1:0] nbits,
  input  wire logic [MW-1:0]               modulus,
  input  wire logic [tlbp_pkg::DVD_W-1:0]  dividend,
  output logic                             done,
  output logic [MW-1:0]                    rem
);
  import tlbp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [MW-1:0]     rem_r, rem_nxt;
  logic [MW-1:0]     mod_r, mod_nxt;
  logic [MW:0]       trial;

  // One quotient bit per cycle, dividend taken from its top bit down
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nbits;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      mod_nxt  = modulus;
    end else if (busy_r) begin
      if (trial >= {1'b0, mod_r}) begin
        rem_nxt = MW'(trial - {1'b0, mod_r});
      end else begin
        rem_nxt = trial[MW-1:0];
      end
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire
